// File: hw/rtl/dmachk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMA channel register checker package
// Shared types and fixed constants of the channel register front end.
// ----------------------------------------------------------------------------
package dmachk_pkg;

	// Operation codes of an input transfer.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_DONE  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Register select codes.
	localparam logic [2:0] REG_TARGET    = 3'd0;
	localparam logic [2:0] REG_SYSTEM    = 3'd1;
	localparam logic [2:0] REG_LENGTH    = 3'd2;
	localparam logic [2:0] REG_DIRECTION = 3'd3;
	localparam logic [2:0] REG_ENABLE    = 3'd4;
	localparam logic [2:0] REG_START     = 3'd5;
	localparam logic [2:0] REG_SUSPEND   = 3'd6;
	localparam logic [2:0] REG_PROTECT   = 3'd7;

	// Legal address areas (address bits 28..26).
	localparam logic [2:0] AREA_TGT_A = 3'd0;
	localparam logic [2:0] AREA_TGT_B = 3'd5;
	localparam logic [2:0] AREA_SYS_A = 3'd1;
	localparam logic [2:0] AREA_SYS_B = 3'd3;

	localparam logic [31:0] ADDR_MASK    = 32'h1FFF_FFE0;
	localparam logic [15:0] PROT_KEY     = 16'h4659;
	localparam logic [14:0] PROT_MASK    = 15'h7f7f;
	localparam logic [14:0] PROT_RESET   = 15'h7f00;
	localparam logic [31:0] WIN_LO_BASE  = 32'h0800_0000;
	localparam logic [31:0] WIN_HI_BASE  = 32'h080f_ffe0;
	localparam logic [31:0] SUSP_IDLE    = 32'h0000_0010;
	localparam logic [31:0] DIR_SWAP     = 32'd1;
	localparam logic [31:0] ENABLE_ON    = 32'd1;

	typedef struct packed {
		logic [31:0] target_addr;
		logic [31:0] system_addr;
		logic [31:0] length_reg;
		logic [31:0] direction;
		logic [31:0] enable_flag;
		logic [1:0]  start_status;
		logic [31:0] suspend_reg;
		logic [14:0] protect_window;
	} dmachk_state_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        copy_valid;
		logic [31:0] copy_src;
		logic [31:0] copy_dst;
		logic [30:0] copy_len;
		logic        irq_done;
		logic        irq_illegal_addr;
		logic        irq_overrun;
	} dmachk_result_t;

endpackage
`default_nettype wire

// File: hw/rtl/dmachk_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMA channel register checker: transfer evaluation
// Computes the next register state and the result of one input transfer.
// ----------------------------------------------------------------------------
module dmachk_exec import dmachk_pkg::*; #(
	parameter int unsigned SHORT_LEN = 128
) (
	input  logic           strict_checks,
	input  dmachk_state_t  cur,
	input  logic [1:0]     op,
	input  logic [2:0]     reg_sel,
	input  logic [31:0]    write_data,
	input  logic           done_irq_pending,
	output dmachk_state_t  nxt,
	output dmachk_result_t res
);

	logic [30:0] len;
	logic [31:0] win_lo;
	logic [31:0] win_hi;
	logic [31:0] src_end;
	logic [2:0]  wr_area;
	logic [2:0]  tgt_area;
	logic [2:0]  sys_area;
	logic        wr_tgt_ok;
	logic        wr_sys_ok;
	logic        tgt_ok;
	logic        sys_ok;
	logic        src_in;
	logic        end_in;
	logic        start_go;
	logic        finish_now;

	always_comb begin
		len      = cur.length_reg[30:0];
		win_lo   = WIN_LO_BASE | {5'd0, cur.protect_window[14:8], 20'd0};
		win_hi   = WIN_HI_BASE | {5'd0, cur.protect_window[6:0], 20'd0};
		src_end  = cur.system_addr + {1'b0, len} - 32'd1;
		wr_area  = write_data[28:26];
		tgt_area = cur.target_addr[28:26];
		sys_area = cur.system_addr[28:26];

		wr_tgt_ok = !strict_checks || wr_area == AREA_TGT_A || wr_area == AREA_TGT_B;
		wr_sys_ok = !strict_checks || wr_area == AREA_SYS_A || wr_area == AREA_SYS_B;
		tgt_ok    = !strict_checks || tgt_area == AREA_TGT_A || tgt_area == AREA_TGT_B;
		sys_ok    = !strict_checks || sys_area == AREA_SYS_A || sys_area == AREA_SYS_B;
		src_in    = !strict_checks ||
			(cur.system_addr >= win_lo && cur.system_addr <= win_hi);
		end_in    = !strict_checks || (src_end >= win_lo && src_end <= win_hi);

		start_go = write_data[0] && !cur.start_status[0] && cur.enable_flag == ENABLE_ON;

		nxt        = cur;
		res        = '0;
		finish_now = 1'b0;

		unique case (op)
			OP_WRITE: begin
				unique case (reg_sel)
					REG_TARGET: begin
						nxt.target_addr      = write_data & ADDR_MASK;
						res.irq_illegal_addr = !wr_tgt_ok;
					end
					REG_SYSTEM: begin
						nxt.system_addr      = write_data & ADDR_MASK;
						res.irq_illegal_addr = !wr_sys_ok;
					end
					REG_LENGTH:    nxt.length_reg  = write_data;
					REG_DIRECTION: nxt.direction   = write_data;
					REG_ENABLE:    nxt.enable_flag = write_data;
					REG_START: begin
						if (start_go) begin
							if (!sys_ok || !tgt_ok) begin
								nxt.start_status     = 2'd0;
								nxt.enable_flag      = '0;
								res.irq_illegal_addr = 1'b1;
							end else if (!src_in || !end_in) begin
								nxt.start_status = 2'd0;
								nxt.enable_flag  = '0;
								res.irq_overrun  = 1'b1;
							end else begin
								res.copy_valid = 1'b1;
								res.copy_len   = len;
								if (cur.direction == DIR_SWAP) begin
									res.copy_src = cur.target_addr;
									res.copy_dst = cur.system_addr;
								end else begin
									res.copy_src = cur.system_addr;
									res.copy_dst = cur.target_addr;
								end
								nxt.start_status = 2'd1;
								nxt.suspend_reg  = cur.suspend_reg & ~SUSP_IDLE;
								finish_now       = len <= 31'(SHORT_LEN);
							end
						end
					end
					REG_SUSPEND: nxt.suspend_reg = write_data;
					REG_PROTECT: begin
						if (write_data[31:16] == PROT_KEY) begin
							nxt.protect_window = write_data[14:0] & PROT_MASK;
						end
					end
					default: ;
				endcase
			end
			OP_READ: begin
				unique case (reg_sel)
					REG_TARGET:    res.read_data = cur.target_addr;
					REG_SYSTEM:    res.read_data = cur.system_addr;
					REG_LENGTH:    res.read_data = cur.length_reg;
					REG_DIRECTION: res.read_data = cur.direction;
					REG_ENABLE:    res.read_data = cur.enable_flag;
					REG_START: begin
						// A pending done interrupt makes the channel look busy once more.
						if (done_irq_pending && !cur.start_status[1]) begin
							nxt.start_status = cur.start_status | 2'b10;
							res.read_data    = 32'd1;
						end else begin
							nxt.start_status = {1'b0, cur.start_status[0]};
							res.read_data    = {31'd0, cur.start_status[0]};
						end
					end
					REG_SUSPEND: res.read_data = cur.suspend_reg;
					default:     res.read_data = '0;
				endcase
			end
			OP_DONE: finish_now = cur.start_status[0];
			default: ;
		endcase

		// Completion only happens on a start or a done event, so the
		// addresses here have not been written in the same transfer.
		if (finish_now) begin
			nxt.enable_flag  = {31'd0, ~cur.length_reg[31]};
			nxt.system_addr  = cur.system_addr + {1'b0, len};
			nxt.target_addr  = cur.target_addr + {1'b0, len};
			nxt.start_status = 2'd0;
			nxt.length_reg   = '0;
			nxt.suspend_reg  = nxt.suspend_reg | SUSP_IDLE;
			res.irq_done     = 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/dma_channel_register_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMA channel register checker
// Register front end of one DMA channel with area and window checks.
// ----------------------------------------------------------------------------
// Every accepted input transfer (register write, register read or done event)
// produces exactly one result transfer. The register state is updated in the
// cycle of acceptance and the result is registered into the output buffer,
// so one transfer per cycle is sustained while the output is not stalled.
// Results wait in a two-entry output buffer; the second entry fills only when
// the output is stalled, and the input stalls for as long as that second entry
// is occupied. strict_checks resets to 1 and should be written only while idle.
module dma_channel_register_checker import dmachk_pkg::*; #(
	parameter int unsigned SHORT_LEN = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [2:0]  reg_sel,
	input  logic [31:0] write_data,
	input  logic        done_irq_pending,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        copy_valid,
	output logic [31:0] copy_src,
	output logic [31:0] copy_dst,
	output logic [30:0] copy_len,
	output logic        irq_done,
	output logic        irq_illegal_addr,
	output logic        irq_overrun
);

	logic           strict_q;
	dmachk_state_t  state_q;
	dmachk_state_t  state_nxt;
	dmachk_result_t res_nxt;
	dmachk_result_t out_q;
	dmachk_result_t skid_q;
	logic           out_valid_q;
	logic           skid_valid_q;
	logic           in_acc;
	logic           out_free;

	dmachk_exec #(
		.SHORT_LEN(SHORT_LEN)
	) u_exec (
		.strict_checks   (strict_q),
		.cur             (state_q),
		.op              (op),
		.reg_sel         (reg_sel),
		.write_data      (write_data),
		.done_irq_pending(done_irq_pending),
		.nxt             (state_nxt),
		.res             (res_nxt)
	);

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b1;
		end else if (cfg_write) begin
			strict_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q                <= '0;
			state_q.protect_window <= PROT_RESET;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_acc;
			skid_valid_q <= 1'b0;
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// The skid entry is always older than a transfer arriving in the same cycle.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res_nxt;
		end
		if (in_acc && !(out_free && !skid_valid_q)) begin
			skid_q <= res_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign read_data        = out_q.read_data;
	assign copy_valid       = out_q.copy_valid;
	assign copy_src         = out_q.copy_src;
	assign copy_dst         = out_q.copy_dst;
	assign copy_len         = out_q.copy_len;
	assign irq_done         = out_q.irq_done;
	assign irq_illegal_addr = out_q.irq_illegal_addr;
	assign irq_overrun      = out_q.irq_overrun;

endmodule
`default_nettype wire
